### design/cpc_pkg.sv
// shared types, constants and helpers for the clipped patch compositor
package cpc_pkg;

   // default sizing for the top level parameters
   localparam int MAX_IMAGE_WIDTH_DEF = 4096;
   localparam int MAX_PATCH_SIDE_DEF  = 256;

   // field widths
   localparam int MODE_W     = 2;
   localparam int PIX_W      = 32;
   localparam int IMG_W_W    = 13;
   localparam int ROW_W      = 16;
   localparam int SIDE_W     = 9;
   localparam int ANCHOR_W   = 16;
   localparam int X_W        = 12;
   localparam int Y_W        = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // signed working width for image coordinates
   localparam int GEO_W = 20;

   // transaction modes
   localparam logic [MODE_W-1:0] MODE_BLANK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PASTE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

   // blank marker, most negative Q16.16 value
   localparam logic [PIX_W-1:0] BLANK_MARK = 32'h8000_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ROW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ROW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_END_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATCH_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PATCH_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_X      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_Y      = 3'd7;

   // register file contents as seen by the evaluation logic
   typedef struct packed {
      logic [ROW_W-1:0]           first_row;
      logic [ROW_W-1:0]           end_row;
      logic [ROW_W-1:0]           blank_end_row;
      logic signed [ANCHOR_W-1:0] anchor_x;
      logic signed [ANCHOR_W-1:0] anchor_y;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      logic                    write_enable;
      logic                    accumulate;
      logic [X_W-1:0]          pixel_x;
      logic [Y_W-1:0]          pixel_y;
      logic signed [PIX_W-1:0] pixel_value;
      logic                    patch_done;
   } result_type;

   // effective patch side: zero acts as one, large values cap at max_side
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                    input int unsigned max_side);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0)
         r = SIDE_W'(1);
      else if (32'(v) > max_side)
         r = SIDE_W'(max_side);
      return r;
   endfunction

endpackage

### design/clipped_patch_compositor_unit.sv
// clipped patch compositor: registers, raster counter, two stage pipeline
// Each transaction is registered in the input stage and then in the result register.
// Throughput: one pixel transaction per cycle unless rsp_stall holds the result.
// req_stall rises only while both the input stage and the result register are full
// and rsp_stall holds the result. Reset is synchronous: it empties the pipeline,
// clears the patch counters and loads the register defaults.
module clipped_patch_compositor_unit #(
   parameter int MAX_IMAGE_WIDTH = cpc_pkg::MAX_IMAGE_WIDTH_DEF,
   parameter int MAX_PATCH_SIDE  = cpc_pkg::MAX_PATCH_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write,
   input  logic [cpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0]     csr_data,
   // pixel transactions in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cpc_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [cpc_pkg::PIX_W-1:0]   req_patch_pixel,
   input  logic signed [cpc_pkg::PIX_W-1:0]   req_fill_or_gain,
   // image update transactions out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_write_enable,
   output logic                               rsp_accumulate,
   output logic [cpc_pkg::X_W-1:0]            rsp_pixel_x,
   output logic [cpc_pkg::Y_W-1:0]            rsp_pixel_y,
   output logic signed [cpc_pkg::PIX_W-1:0]   rsp_pixel_value,
   output logic                               rsp_patch_done
);

   localparam int CNT_W = $clog2(MAX_PATCH_SIDE);

   // configuration registers
   logic [cpc_pkg::IMG_W_W-1:0]          image_width_ff;
   logic [cpc_pkg::SIDE_W-1:0]           patch_width_ff, patch_height_ff;
   cpc_pkg::cfg_type                     cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff       <= cpc_pkg::IMG_W_W'(4096);
         patch_width_ff       <= cpc_pkg::SIDE_W'(1);
         patch_height_ff      <= cpc_pkg::SIDE_W'(1);
         cfg_ff.first_row     <= '0;
         cfg_ff.end_row       <= '1;
         cfg_ff.blank_end_row <= '1;
         cfg_ff.anchor_x      <= '0;
         cfg_ff.anchor_y      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cpc_pkg::CSR_IMAGE_WIDTH:   image_width_ff <= csr_data[cpc_pkg::IMG_W_W-1:0];
            cpc_pkg::CSR_FIRST_ROW:     cfg_ff.first_row <= csr_data;
            cpc_pkg::CSR_END_ROW:       cfg_ff.end_row <= csr_data;
            cpc_pkg::CSR_BLANK_END_ROW: cfg_ff.blank_end_row <= csr_data;
            cpc_pkg::CSR_PATCH_WIDTH:   patch_width_ff <= csr_data[cpc_pkg::SIDE_W-1:0];
            cpc_pkg::CSR_PATCH_HEIGHT:  patch_height_ff <= csr_data[cpc_pkg::SIDE_W-1:0];
            cpc_pkg::CSR_ANCHOR_X:      cfg_ff.anchor_x <= csr_data;
            cpc_pkg::CSR_ANCHOR_Y:      cfg_ff.anchor_y <= csr_data;
            default: ;
         endcase
      end
   end

   // effective image width and patch sides
   logic [cpc_pkg::IMG_W_W-1:0] image_width_eff;
   logic [cpc_pkg::SIDE_W-1:0]  side_w, side_h;

   assign image_width_eff = (32'(image_width_ff) > MAX_IMAGE_WIDTH) ?
                            cpc_pkg::IMG_W_W'(MAX_IMAGE_WIDTH) : image_width_ff;
   assign side_w = cpc_pkg::clamp_side(patch_width_ff, MAX_PATCH_SIDE);
   assign side_h = cpc_pkg::clamp_side(patch_height_ff, MAX_PATCH_SIDE);

   // pipeline handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s1_move, req_take;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_stall    = s1_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // patch position counters advance on each accepted transaction
   logic [CNT_W-1:0] cnt_column, cnt_row;
   logic             cnt_done;

   cpc_raster_counter #(
      .MAX_PATCH_SIDE(MAX_PATCH_SIDE)
   ) u_counter (
      .clock  (clock),
      .reset  (reset),
      .advance(req_take),
      .side_w (side_w),
      .side_h (side_h),
      .column (cnt_column),
      .row    (cnt_row),
      .done   (cnt_done)
   );

   // input stage
   logic [cpc_pkg::MODE_W-1:0]       s1_mode_ff;
   logic signed [cpc_pkg::PIX_W-1:0] s1_pixel_ff, s1_fg_ff;
   logic [CNT_W-1:0]                 s1_column_ff, s1_row_ff;
   logic                             s1_done_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff   <= req_mode;
         s1_pixel_ff  <= req_patch_pixel;
         s1_fg_ff     <= req_fill_or_gain;
         s1_column_ff <= cnt_column;
         s1_row_ff    <= cnt_row;
         s1_done_ff   <= cnt_done;
      end
   end

   // evaluation between input stage and result register
   cpc_pkg::result_type eval_result;

   cpc_pixel_eval #(
      .MAX_PATCH_SIDE(MAX_PATCH_SIDE)
   ) u_eval (
      .cfg         (cfg_ff),
      .image_width (image_width_eff),
      .side_w      (side_w),
      .side_h      (side_h),
      .mode        (s1_mode_ff),
      .patch_pixel (s1_pixel_ff),
      .fill_or_gain(s1_fg_ff),
      .column      (s1_column_ff),
      .row         (s1_row_ff),
      .done        (s1_done_ff),
      .result      (eval_result)
   );

   // result register
   cpc_pkg::result_type rsp_ff;

   always_ff @(posedge clock) begin
      if (s1_move)
         rsp_ff <= eval_result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_ff.write_enable;
   assign rsp_accumulate   = rsp_ff.accumulate;
   assign rsp_pixel_x      = rsp_ff.pixel_x;
   assign rsp_pixel_y      = rsp_ff.pixel_y;
   assign rsp_pixel_value  = rsp_ff.pixel_value;
   assign rsp_patch_done   = rsp_ff.patch_done;

   // accumulate only accompanies a write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_accumulate |-> rsp_write_enable)
      else $error("accumulate without write enable");

   // a result without a write carries zero position and value fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_write_enable |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_value == '0)
      else $error("non-write result carries data");

   // input is held off only when both stages are full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // a blocked input stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && rsp_valid_ff)
      else $error("pipeline dropped a transaction");

endmodule

### design/cpc_raster_counter.sv
// column and row position of the incoming patch pixel, with end of patch flag
module cpc_raster_counter #(
   parameter int MAX_PATCH_SIDE = cpc_pkg::MAX_PATCH_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [cpc_pkg::SIDE_W-1:0]       side_w,
   input  logic [cpc_pkg::SIDE_W-1:0]       side_h,
   output logic [$clog2(MAX_PATCH_SIDE)-1:0] column,
   output logic [$clog2(MAX_PATCH_SIDE)-1:0] row,
   output logic                             done
);

   localparam int CNT_W = $clog2(MAX_PATCH_SIDE);
   localparam int CMP_W = ((CNT_W > cpc_pkg::SIDE_W) ? CNT_W : cpc_pkg::SIDE_W) + 1;

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             col_wrap;
   logic             row_wrap;

   // wrap tests on the current position
   assign col_wrap = (CMP_W'(column_ff) + CMP_W'(1)) >= CMP_W'(side_w);
   assign row_wrap = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(side_h);

   // next position
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (col_wrap) begin
            column_in = '0;
            if (row_wrap)
               row_in = '0;
            else
               row_in = row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign column = column_ff;
   assign row    = row_ff;
   assign done   = col_wrap && row_wrap;

endmodule

### design/cpc_pixel_eval.sv
// placement, clipping and value selection for one patch pixel
module cpc_pixel_eval #(
   parameter int MAX_PATCH_SIDE = cpc_pkg::MAX_PATCH_SIDE_DEF
) (
   input  cpc_pkg::cfg_type                   cfg,
   input  logic [cpc_pkg::IMG_W_W-1:0]        image_width,
   input  logic [cpc_pkg::SIDE_W-1:0]         side_w,
   input  logic [cpc_pkg::SIDE_W-1:0]         side_h,
   input  logic [cpc_pkg::MODE_W-1:0]         mode,
   input  logic signed [cpc_pkg::PIX_W-1:0]   patch_pixel,
   input  logic signed [cpc_pkg::PIX_W-1:0]   fill_or_gain,
   input  logic [$clog2(MAX_PATCH_SIDE)-1:0]  column,
   input  logic [$clog2(MAX_PATCH_SIDE)-1:0]  row,
   input  logic                               done,
   output cpc_pkg::result_type                result
);

   localparam int CNT_W = $clog2(MAX_PATCH_SIDE);
   localparam int GW    = cpc_pkg::GEO_W;
   localparam int PW    = cpc_pkg::PIX_W;
   localparam int SW    = cpc_pkg::SIDE_W;

   logic signed [GW-1:0]   ax, ay, half_w, half_h, w_s, h_s;
   logic signed [GW-1:0]   x0, y0, x, y;
   logic signed [GW-1:0]   iw_s, first_s, end_s, bound_s;
   logic                   is_add, is_blank;
   logic                   in_x, in_y, outside, marker, we;
   logic signed [2*PW-1:0] prod;
   logic signed [2*PW-17:0] shifted;
   logic [PW-1:0]          scaled;
   logic [PW-1:0]          value;

   // operands widened to the coordinate width
   always_comb begin
      ax      = {{(GW-cpc_pkg::ANCHOR_W){cfg.anchor_x[cpc_pkg::ANCHOR_W-1]}}, cfg.anchor_x};
      ay      = {{(GW-cpc_pkg::ANCHOR_W){cfg.anchor_y[cpc_pkg::ANCHOR_W-1]}}, cfg.anchor_y};
      half_w  = {{(GW-SW+1){1'b0}}, side_w[SW-1:1]};
      half_h  = {{(GW-SW+1){1'b0}}, side_h[SW-1:1]};
      w_s     = {{(GW-SW){1'b0}}, side_w};
      h_s     = {{(GW-SW){1'b0}}, side_h};
      iw_s    = {{(GW-cpc_pkg::IMG_W_W){1'b0}}, image_width};
      first_s = {{(GW-cpc_pkg::ROW_W){1'b0}}, cfg.first_row};
      end_s   = {{(GW-cpc_pkg::ROW_W){1'b0}}, cfg.end_row};
   end

   assign is_blank = (mode == cpc_pkg::MODE_BLANK);
   assign is_add   = (mode == cpc_pkg::MODE_ADD);

   // patch origin: top left corner, or centred on the anchor when adding
   always_comb begin
      if (is_add) begin
         x0 = ax - half_w;
         y0 = ay - half_h;
      end else begin
         x0 = ax;
         y0 = ay;
      end
      x = x0 + {{(GW-CNT_W){1'b0}}, column};
      y = y0 + {{(GW-CNT_W){1'b0}}, row};
      if (is_blank)
         bound_s = {{(GW-cpc_pkg::ROW_W){1'b0}}, cfg.blank_end_row};
      else
         bound_s = end_s;
   end

   // clip tests
   assign in_x    = (x >= 0) && (x < iw_s);
   assign in_y    = (y >= first_s) && (y < bound_s);
   assign outside = ((x0 + w_s) < 0) || (x0 >= iw_s) ||
                    ((y0 + h_s) < first_s) || (y0 >= end_s);
   assign marker  = (patch_pixel == cpc_pkg::BLANK_MARK);

   // gain times pixel, floor to Q16.16, saturate
   always_comb begin
      prod    = 64'(fill_or_gain) * 64'(patch_pixel);
      shifted = prod[2*PW-1:16];
      if (shifted[2*PW-17:PW-1] == '0 || shifted[2*PW-17:PW-1] == '1)
         scaled = shifted[PW-1:0];
      else if (shifted[2*PW-17])
         scaled = {1'b1, {(PW-1){1'b0}}};
      else
         scaled = {1'b0, {(PW-1){1'b1}}};
   end

   // write decision and value per mode
   always_comb begin
      we    = 1'b0;
      value = '0;
      case (mode)
         cpc_pkg::MODE_BLANK: begin
            we    = in_x && in_y && !outside && !marker;
            value = fill_or_gain;
         end
         cpc_pkg::MODE_PASTE: begin
            we    = in_x && in_y && !outside && !marker;
            value = patch_pixel;
         end
         cpc_pkg::MODE_ADD: begin
            we    = in_x && in_y;
            value = scaled;
         end
         default: begin
            we    = 1'b0;
            value = '0;
         end
      endcase
   end

   // position and value fields read as zero when nothing is written
   always_comb begin
      result.write_enable = we;
      result.accumulate   = we && is_add;
      result.pixel_x      = we ? x[cpc_pkg::X_W-1:0] : '0;
      result.pixel_y      = we ? y[cpc_pkg::Y_W-1:0] : '0;
      result.pixel_value  = we ? value : '0;
      result.patch_done   = done;
   end

endmodule
